### rtl/rpd_pkg.sv
// Shared constants, configuration struct and state type for the range to planar depth block.
package rpd_pkg;

    localparam int FOCAL_W    = 22;
    localparam int CENTER_W   = 20;
    localparam int FRAME_W    = 13;
    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int FRAC_W     = 8;
    localparam int NORM_SHIFT = 16;
    localparam int LIMIT_W    = FRAME_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    localparam logic [FOCAL_W-1:0]  FOCAL_X_RST      = 22'd122880;
    localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST      = 22'd122880;
    localparam logic [CENTER_W-1:0] CENTER_X_RST     = 20'd81920;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST     = 20'd61440;
    localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RST = 13'd480;

    localparam logic [FOCAL_W-1:0]  FOCAL_MIN = 22'd256;

    typedef struct packed {
        logic [FOCAL_W-1:0]  focal_x;
        logic [FOCAL_W-1:0]  focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [FRAME_W-1:0]  frame_width;
        logic [FRAME_W-1:0]  frame_height;
    } cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV_A,
        BK_DIV_B,
        BK_SQ_A,
        BK_SQ_B,
        BK_ROOT,
        BK_ROUND,
        BK_DIV_Z,
        BK_EMIT
    } back_state_t;

endpackage

### rtl/rpd_if.sv
// Stream interfaces for range samples in and depth results out.
interface rpd_in_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] range_sample;

    modport source (output valid, output range_sample, input ready);
    modport sink   (input valid, input range_sample, output ready);
endinterface

interface rpd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] planar_depth;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic        frame_last;

    modport source (output valid, output planar_depth, output pixel_col,
                    output pixel_row, output frame_last, input ready);
    modport sink   (input valid, input planar_depth, input pixel_col,
                    input pixel_row, input frame_last, output ready);
endinterface

### rtl/rpd_fifo.sv
// Small register queue between the front and back parts.
module rpd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

### rtl/rpd_front.sv
// Front part: raster counters, last-pixel flag and principal point offsets.
module rpd_front #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int DXW         = 21,
    parameter int ENTRY_W     = SAMPLE_BITS + 2 * rpd_pkg::COORD_W + 1 + 2 * DXW
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rpd_in_if.sink               in_ch,
    input  rpd_pkg::cfg_t        cfg,
    input  logic                 full,
    output logic                 push,
    output logic [ENTRY_W-1:0]   entry
);
    import rpd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]      col_reg;
    logic [HW-1:0]      row_reg;
    logic [LIMIT_W-1:0] w_use;
    logic [LIMIT_W-1:0] h_use;
    logic [LIMIT_W-1:0] fw;
    logic [LIMIT_W-1:0] fh;
    logic               row_end;
    logic               frame_end;
    logic [DXW-1:0]     px;
    logic [DXW-1:0]     py;
    logic [DXW-1:0]     cx;
    logic [DXW-1:0]     cy;
    logic [DXW-1:0]     dx;
    logic [DXW-1:0]     dy;

    assign fw = LIMIT_W'(cfg.frame_width);
    assign fh = LIMIT_W'(cfg.frame_height);

    always_comb
    begin
        priority if (fw == '0)
            w_use = LIMIT_W'(1);
        else if (fw > LIMIT_W'(MAX_WIDTH))
            w_use = LIMIT_W'(MAX_WIDTH);
        else
            w_use = fw;
        priority if (fh == '0)
            h_use = LIMIT_W'(1);
        else if (fh > LIMIT_W'(MAX_HEIGHT))
            h_use = LIMIT_W'(MAX_HEIGHT);
        else
            h_use = fh;
    end

    assign row_end   = (LIMIT_W'(col_reg) + LIMIT_W'(1)) >= w_use;
    assign frame_end = row_end && ((LIMIT_W'(row_reg) + LIMIT_W'(1)) >= h_use);

    assign px = DXW'(col_reg) << FRAC_W;
    assign py = DXW'(row_reg) << FRAC_W;
    assign cx = DXW'(cfg.center_x);
    assign cy = DXW'(cfg.center_y);
    assign dx = (px >= cx) ? px - cx : cx - px;
    assign dy = (py >= cy) ? py - cy : cy - py;

    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;
    assign entry = {in_ch.range_sample, COORD_W'(col_reg), COORD_W'(row_reg),
                    frame_end, dx, dy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end
endmodule

### rtl/rpd_div.sv
// Restoring divider, one quotient bit per cycle.
module rpd_div #(
    parameter int NUMW = 48,
    parameter int DENW = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [NUMW-1:0] quo
);
    localparam int CNTW = $clog2(NUMW + 1);

    logic [NUMW-1:0] quo_reg;
    logic [DENW-1:0] den_reg;
    logic [DENW-1:0] rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DENW:0]   rem_sh;
    logic [DENW:0]   rem_diff;
    logic            ge;

    assign rem_sh   = {rem_reg, quo_reg[NUMW-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign done     = done_reg;
    assign quo      = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? rem_diff[DENW-1:0] : rem_sh[DENW-1:0];
            quo_reg <= {quo_reg[NUMW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNTW'(NUMW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNTW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end
endmodule

### rtl/rpd_back.sv
// Back part: offset normalization, root of the ray length and the final divide.
module rpd_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int DXW         = 21,
    parameter int ENTRY_W     = SAMPLE_BITS + 2 * rpd_pkg::COORD_W + 1 + 2 * DXW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rpd_pkg::cfg_t       cfg,
    input  logic [ENTRY_W-1:0]  entry,
    input  logic                empty,
    output logic                pop,
    rpd_out_if.source           out_ch
);
    import rpd_pkg::*;

    localparam int AW   = DXW + 9;
    localparam int SW   = 2 * AW + 1;
    localparam int SQW  = SW + (SW % 2);
    localparam int RW   = AW + 2;
    localparam int NUMW = ((DXW > SAMPLE_BITS) ? DXW : SAMPLE_BITS) + NORM_SHIFT + 1;
    localparam int DENW = (FOCAL_W > RW) ? FOCAL_W : RW;

    back_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] e_z;
    logic [COORD_W-1:0]     e_col;
    logic [COORD_W-1:0]     e_row;
    logic                   e_last;
    logic [DXW-1:0]         e_dx;
    logic [DXW-1:0]         e_dy;

    logic [SAMPLE_BITS-1:0] z_reg;
    logic [COORD_W-1:0]     col_reg;
    logic [COORD_W-1:0]     row_reg;
    logic                   last_reg;
    logic [DXW-1:0]         dy_reg;
    logic [AW-1:0]          a_reg;
    logic [AW-1:0]          b_reg;
    logic [SQW-1:0]         acc_reg;
    logic [SQW-1:0]         rest_reg;
    logic [SQW-1:0]         res_reg;
    logic [SQW-1:0]         bit_reg;
    logic [DEPTH_W-1:0]     depth_reg;

    logic                   out_valid_reg;
    logic [DEPTH_W-1:0]     out_depth_reg;
    logic [COORD_W-1:0]     out_col_reg;
    logic [COORD_W-1:0]     out_row_reg;
    logic                   out_last_reg;

    logic [FOCAL_W-1:0]     fx;
    logic [FOCAL_W-1:0]     fy;
    logic [2*AW-1:0]        a_sq;
    logic [2*AW-1:0]        b_sq;
    logic [SQW-1:0]         trial;
    logic                   take;
    logic [SQW-1:0]         root;
    logic [RW-1:0]          r_val;
    logic                   div_start;
    logic [NUMW-1:0]        div_num;
    logic [DENW-1:0]        div_den;
    logic                   div_done;
    logic [NUMW-1:0]        div_quo;
    logic                   out_free;

    assign {e_z, e_col, e_row, e_last, e_dx, e_dy} = entry;

    assign fx = (cfg.focal_x < FOCAL_MIN) ? FOCAL_MIN : cfg.focal_x;
    assign fy = (cfg.focal_y < FOCAL_MIN) ? FOCAL_MIN : cfg.focal_y;

    assign a_sq  = a_reg * a_reg;
    assign b_sq  = b_reg * b_reg;
    assign trial = res_reg + bit_reg;
    assign take  = rest_reg >= trial;
    assign root  = res_reg + SQW'(rest_reg > res_reg);
    assign r_val = RW'(root);

    assign out_free = !out_valid_reg || out_ch.ready;
    assign pop      = (state_reg == BK_IDLE) && !empty;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                div_start = !empty;
                div_num   = (NUMW'(e_dx) << NORM_SHIFT) + NUMW'(fx >> 1);
                div_den   = DENW'(fx);
            end
            BK_DIV_A:
            begin
                div_start = div_done;
                div_num   = (NUMW'(dy_reg) << NORM_SHIFT) + NUMW'(fy >> 1);
                div_den   = DENW'(fy);
            end
            BK_ROUND:
            begin
                div_start = 1'b1;
                div_num   = (NUMW'(z_reg) << NORM_SHIFT) + NUMW'(r_val >> 1);
                div_den   = DENW'(r_val);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (!empty) state_next = BK_DIV_A;
            BK_DIV_A: if (div_done) state_next = BK_DIV_B;
            BK_DIV_B: if (div_done) state_next = BK_SQ_A;
            BK_SQ_A:  state_next = BK_SQ_B;
            BK_SQ_B:  state_next = BK_ROOT;
            BK_ROOT:  if (bit_reg[0]) state_next = BK_ROUND;
            BK_ROUND: state_next = BK_DIV_Z;
            BK_DIV_Z: if (div_done) state_next = BK_EMIT;
            BK_EMIT:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    z_reg    <= e_z;
                    col_reg  <= e_col;
                    row_reg  <= e_row;
                    last_reg <= e_last;
                    dy_reg   <= e_dy;
                end
            end
            BK_DIV_A:
            begin
                if (div_done)
                begin
                    a_reg <= AW'(div_quo);
                end
            end
            BK_DIV_B:
            begin
                if (div_done)
                begin
                    b_reg <= AW'(div_quo);
                end
            end
            BK_SQ_A:
            begin
                acc_reg <= SQW'(a_sq);
            end
            BK_SQ_B:
            begin
                rest_reg <= acc_reg + SQW'(b_sq) + (SQW'(1) << 32);
                res_reg  <= '0;
                bit_reg  <= SQW'(1) << (SQW - 2);
            end
            BK_ROOT:
            begin
                if (take)
                begin
                    rest_reg <= rest_reg - trial;
                    res_reg  <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            BK_DIV_Z:
            begin
                if (div_done)
                begin
                    depth_reg <= DEPTH_W'(div_quo);
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_depth_reg <= depth_reg;
                    out_col_reg   <= col_reg;
                    out_row_reg   <= row_reg;
                    out_last_reg  <= last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    rpd_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.planar_depth = out_depth_reg;
    assign out_ch.pixel_col    = out_col_reg;
    assign out_ch.pixel_row    = out_row_reg;
    assign out_ch.frame_last   = out_last_reg;
endmodule

### rtl/range_to_planar_depth.sv
// Top level of the range to planar depth converter.
// Each range sample is tagged with its raster position at input and queued; the
// back end then turns it into depth along the optical axis. The time per item is
// set by the shared one-bit-per-cycle divider used three times per pixel and the
// two-bit-per-cycle square root. A two-entry queue lets the input side take new
// samples while a result waits. Write configuration only while no pixel is in
// flight.
module range_to_planar_depth #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rpd_in_if.sink                         in_ch,
    rpd_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rpd_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int HW      = $clog2(MAX_HEIGHT);
    localparam int PMAX    = ((CW > HW) ? CW : HW) + FRAC_W;
    localparam int DXW     = (PMAX > CENTER_W) ? PMAX : CENTER_W;
    localparam int ENTRY_W = SAMPLE_BITS + 2 * COORD_W + 1 + 2 * DXW;

    cfg_t               cfg_reg;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x      <= FOCAL_X_RST;
            cfg_reg.focal_y      <= FOCAL_Y_RST;
            cfg_reg.center_x     <= CENTER_X_RST;
            cfg_reg.center_y     <= CENTER_Y_RST;
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FOCAL_X:      cfg_reg.focal_x      <= FOCAL_W'(cfg_data);
                REG_FOCAL_Y:      cfg_reg.focal_y      <= FOCAL_W'(cfg_data);
                REG_CENTER_X:     cfg_reg.center_x     <= CENTER_W'(cfg_data);
                REG_CENTER_Y:     cfg_reg.center_y     <= CENTER_W'(cfg_data);
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= FRAME_W'(cfg_data);
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= FRAME_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    rpd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DXW         (DXW),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg_reg),
        .full  (full),
        .push  (push),
        .entry (wr_entry)
    );

    rpd_fifo #(
        .W     (ENTRY_W),
        .DEPTH (2)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .full    (full),
        .empty   (empty)
    );

    rpd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DXW         (DXW),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .entry  (rd_entry),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> !empty)
        else $error("queued transfer lost");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> !push || $past(pop) || !full)
        else $error("queue overrun");
endmodule

### sim/tb.sv
// Self-checking testbench for range_to_planar_depth: raster depth conversion over many settings.
module tb;
    import rpd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } pixel_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rpd_in_if #(.SAMPLE_BITS(16)) in_ch ();
    rpd_out_if out_ch ();

    range_to_planar_depth dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    pixel_result_t pending_depths[$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;
    int quiet_cycles;

    logic [FOCAL_W-1:0]  m_focal_x, m_focal_y;
    logic [CENTER_W-1:0] m_center_x, m_center_y;
    logic [FRAME_W-1:0]  m_width, m_height;
    int m_col, m_row;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint unsigned round_root(input longint unsigned x);
        longint unsigned rest, res, b;
        rest = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > rest)
            b >>= 2;
        while (b != 0)
        begin
            if (rest >= res + b)
            begin
                rest -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        if (rest > res)
            res++;
        return res;
    endfunction

    function automatic longint unsigned offset_q16(input longint unsigned pos,
                                                   input longint unsigned ctr,
                                                   input longint unsigned focal);
        longint unsigned p, d;
        p = pos * 256;
        d = (p >= ctr) ? p - ctr : ctr - p;
        return ((d << 16) + (focal >> 1)) / focal;
    endfunction

    function automatic pixel_result_t project_pixel(input logic [15:0] z);
        pixel_result_t res;
        longint unsigned fx, fy, w, h, a, b, r;
        logic row_end, frame_end;
        fx = (m_focal_x < FOCAL_MIN) ? FOCAL_MIN : m_focal_x;
        fy = (m_focal_y < FOCAL_MIN) ? FOCAL_MIN : m_focal_y;
        w = (m_width == 0) ? 1 : (m_width > 4096) ? 4096 : m_width;
        h = (m_height == 0) ? 1 : (m_height > 4096) ? 4096 : m_height;
        a = offset_q16(m_col, m_center_x, fx);
        b = offset_q16(m_row, m_center_y, fy);
        r = round_root(a * a + b * b + (64'd1 << 32));
        res.depth = DEPTH_W'(((longint'(z) << 16) + (r >> 1)) / r);
        res.col = COORD_W'(m_col);
        res.row = COORD_W'(m_row);
        row_end = (m_col + 1) >= w;
        frame_end = row_end && ((m_row + 1) >= h);
        res.last = frame_end;
        if (row_end)
        begin
            m_col = 0;
            m_row = frame_end ? 0 : m_row + 1;
        end
        else
            m_col++;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR t=%0t %s got %0d expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    task automatic send_sample(input logic [15:0] z);
        pixel_result_t item;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.range_sample <= z;
        do
            @(posedge clk);
        while (!in_ch.ready);
        item = project_pixel(z);
        pending_depths = {pending_depths, item};
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending_depths.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FOCAL_X:      m_focal_x = val[FOCAL_W-1:0];
            REG_FOCAL_Y:      m_focal_y = val[FOCAL_W-1:0];
            REG_CENTER_X:     m_center_x = val[CENTER_W-1:0];
            REG_CENTER_Y:     m_center_y = val[CENTER_W-1:0];
            REG_FRAME_WIDTH:  m_width = val[FRAME_W-1:0];
            REG_FRAME_HEIGHT: m_height = val[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic random_settings();
        int pick;
        pick = $urandom_range(9);
        write_reg(REG_FOCAL_X, pick == 0 ? $urandom_range(255) : $urandom_range(4194303, 256));
        pick = $urandom_range(9);
        write_reg(REG_FOCAL_Y, pick == 0 ? $urandom_range(4194303) : $urandom_range(8192, 256));
        write_reg(REG_CENTER_X, $urandom_range(4194303));
        write_reg(REG_CENTER_Y, $urandom_range(1048575));
        pick = $urandom_range(19);
        if (pick == 0)
            set_frame(0, $urandom_range(5));
        else if (pick == 1)
            set_frame(8191, 2);
        else if (pick == 2)
            set_frame(4096, 1);
        else
            set_frame($urandom_range(12, 1), $urandom_range(6, 1));
    endtask

    task automatic test_reset_settings();
        send_sample(16'd0);
        send_sample(16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_sample(16'($urandom));
        drain_results();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_FOCAL_X, 0);
        write_reg(REG_FOCAL_Y, 4194303);
        write_reg(REG_CENTER_X, 0);
        write_reg(REG_CENTER_Y, 4194303);
        set_frame(2, 2);
        write_reg(REG_SPARE_LO, 12345);
        write_reg(REG_SPARE_HI, 4194303);
        for (int i = 0; i < 5; i++)
            send_sample(i[0] ? 16'hFFFF : 16'h8000);
        drain_results();
        write_reg(REG_FOCAL_X, 4194303);
        write_reg(REG_FOCAL_Y, 255);
        write_reg(REG_CENTER_X, 4194303);
        write_reg(REG_CENTER_Y, 0);
        set_frame(0, 0);
        for (int i = 0; i < 3; i++)
            send_sample(16'hFFFF);
        drain_results();
    endtask

    task automatic test_frame_shrink();
        write_reg(REG_FOCAL_X, 256);
        write_reg(REG_FOCAL_Y, 256);
        set_frame(8191, 8191);
        for (int i = 0; i < 7; i++)
            send_sample(16'($urandom));
        drain_results();
        set_frame(3, 1);
        for (int i = 0; i < 4; i++)
            send_sample(16'($urandom));
        drain_results();
    endtask

    task automatic test_backpressure();
        set_frame(5, 3);
        recv_hold = 1500;
        for (int i = 0; i < 8; i++)
            send_sample(16'($urandom));
        drain_results();
    endtask

    task automatic test_random_phase(input int s_idle, input int r_idle, input int count);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i++)
        begin
            if (i % 90 == 0)
            begin
                drain_results();
                random_settings();
            end
            send_sample(16'($urandom));
        end
        drain_results();
    endtask

    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_depths.size() == 0)
            begin
                $display("ERROR t=%0t unexpected transfer", $realtime);
                errors++;
            end
            else
            begin
                want = pending_depths.pop_front();
                if (out_ch.planar_depth !== want.depth)
                    report_mismatch("planar_depth", out_ch.planar_depth, want.depth);
                if (out_ch.pixel_col !== want.col)
                    report_mismatch("pixel_col", out_ch.pixel_col, want.col);
                if (out_ch.pixel_row !== want.row)
                    report_mismatch("pixel_row", out_ch.pixel_row, want.row);
                if (out_ch.frame_last !== want.last)
                    report_mismatch("frame_last", out_ch.frame_last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("range_to_planar_depth: mismatch");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        in_ch.valid = 1'b0;
        in_ch.range_sample = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_focal_x = FOCAL_X_RST;
        m_focal_y = FOCAL_Y_RST;
        m_center_x = CENTER_X_RST;
        m_center_y = CENTER_Y_RST;
        m_width = FRAME_WIDTH_RST;
        m_height = FRAME_HEIGHT_RST;
        m_col = 0;
        m_row = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_settings();
        test_config_extremes();
        test_frame_shrink();
        test_backpressure();
        test_random_phase(32, 77, 630);
        test_random_phase(77, 32, 630);
        test_random_phase(0, 0, 630);

        if (errors == 0)
            $display("range_to_planar_depth: match");
        else
            $display("range_to_planar_depth: mismatch");
        $finish;
    end
endmodule
